// File: hw/rtl/ufr_pkg.sv
// ----------------------------------------------------------------------------
// ufr_pkg: shared types and constants of the receive frame ring
// Payload structs of the request and response channels, item modes,
// configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package ufr_pkg;

   localparam int unsigned READ_INDEX_W = 6;
   localparam int unsigned IDLE_W       = 16;
   localparam int unsigned CSR_DATA_W   = 16;

   localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 16'd15;

   typedef enum logic [1:0] {
      MODE_BYTE    = 2'd0,
      MODE_TICK    = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_READ    = 2'd3
   } mode_type;

   typedef enum logic [0:0] {
      CSR_TIMEOUT    = 1'b0,
      CSR_XOR_ENABLE = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      ST_IDLE   = 1'b0,
      ST_FINISH = 1'b1
   } state_type;

   typedef struct packed {
      mode_type                mode;
      logic [7:0]              rx_byte;
      logic [READ_INDEX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [2:0] frames_used;
      logic [6:0] tail_length;
      logic [7:0] tail_xor;
      logic [7:0] read_data;
      logic       frame_closed;
      logic       byte_dropped;
      logic       overflow;
   } rsp_type;

endpackage

// File: hw/rtl/ufr_byte_store.sv
// ----------------------------------------------------------------------------
// ufr_byte_store: frame byte memory
// One write and one read port, each addressed by frame slot and byte
// position; read data is registered.
// ----------------------------------------------------------------------------
module ufr_byte_store #(
   parameter int unsigned FRAME_COUNT = 4,
   parameter int unsigned FRAME_BYTES = 64
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(FRAME_COUNT)-1:0] wr_slot,
   input  logic [$clog2(FRAME_BYTES)-1:0] wr_pos,
   input  logic [7:0]                     wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(FRAME_COUNT)-1:0] rd_slot,
   input  logic [$clog2(FRAME_BYTES)-1:0] rd_pos,
   output logic [7:0]                     rd_data
);

   localparam int unsigned BW    = $clog2(FRAME_BYTES);
   localparam int unsigned DEPTH = FRAME_COUNT * (2 ** BW);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{wr_slot, wr_pos}] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[{rd_slot, rd_pos}];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/ufr_meta_store.sv
// ----------------------------------------------------------------------------
// ufr_meta_store: closed frame length and xor memory
// Written when the head frame closes, read when the tail moves on to the
// next closed frame; read data is registered.
// ----------------------------------------------------------------------------
module ufr_meta_store #(
   parameter int unsigned FRAME_COUNT = 4,
   parameter int unsigned FRAME_BYTES = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(FRAME_COUNT)-1:0]   wr_slot,
   input  logic [$clog2(FRAME_BYTES+1)-1:0] wr_len,
   input  logic [7:0]                       wr_xor,
   input  logic                             rd_en,
   input  logic [$clog2(FRAME_COUNT)-1:0]   rd_slot,
   output logic [$clog2(FRAME_BYTES+1)-1:0] rd_len,
   output logic [7:0]                       rd_xor
);

   localparam int unsigned LW = $clog2(FRAME_BYTES + 1);

   logic [LW+7:0] mem [FRAME_COUNT];
   logic [LW+7:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= {wr_len, wr_xor};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= mem[rd_slot];
      end
   end

   assign rd_len = rd_word_ff[LW+7:8];
   assign rd_xor = rd_word_ff[7:0];

endmodule

// File: hw/rtl/uart_rx_frame_ring.sv
// ----------------------------------------------------------------------------
// uart_rx_frame_ring: ring of received byte frames with idle timeout
// Collects received bytes into frames, closes a frame on idle timeout or
// when full, and hands closed frames out from the tail of the ring.
// ----------------------------------------------------------------------------
// Each request passes through the idle state, in which it is transferred,
// the head and tail state is updated and the frame byte memory or the closed
// frame memory is read, and the finish state, which takes that memory's
// registered read data and loads the response into the output register.
// The request side is stalled during the finish state, which lasts while that
// register still holds an untaken response; a finished response waiting on
// rsp_stall does not block the next request transfer. Configuration writes are
// always taken (csr_ready is tied high) and are meant for idle periods only.
// Byte memory is not cleared; a read outside the tail frame returns zero.
module uart_rx_frame_ring #(
   parameter int unsigned FRAME_COUNT = 4,
   parameter int unsigned FRAME_BYTES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ufr_pkg::req_type      req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ufr_pkg::rsp_type      rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  ufr_pkg::csr_index_type csr_index,
   input  logic [ufr_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import ufr_pkg::*;

   localparam int unsigned SW = $clog2(FRAME_COUNT);
   localparam int unsigned UW = $clog2(FRAME_COUNT + 1);
   localparam int unsigned BW = $clog2(FRAME_BYTES);
   localparam int unsigned LW = $clog2(FRAME_BYTES + 1);
   localparam int unsigned CW = (LW > READ_INDEX_W) ? LW : READ_INDEX_W;

   localparam logic [SW-1:0] SLOT_LAST = SW'(FRAME_COUNT - 1);
   localparam logic [UW-1:0] USED_MAX  = UW'(FRAME_COUNT);
   localparam logic [LW-1:0] LEN_MAX   = LW'(FRAME_BYTES);
   localparam logic [CW-1:0] POS_LIMIT = CW'(FRAME_BYTES);

   // control state
   state_type          state_ff, state_in;
   logic [SW-1:0]      head_slot_ff, head_slot_in;
   logic [SW-1:0]      tail_slot_ff, tail_slot_in;
   logic [UW-1:0]      used_ff, used_in;
   logic               ovf_ff, ovf_in;
   logic [IDLE_W-1:0]  idle_ff, idle_in;
   logic               armed_ff, armed_in;
   logic [LW-1:0]      head_len_ff, head_len_in;
   logic [7:0]         head_xor_ff, head_xor_in;
   logic [LW-1:0]      tail_len_ff, tail_len_in;
   logic [7:0]         tail_xor_ff, tail_xor_in;
   logic               pend_ff, pend_in;
   logic               closed_ff, closed_in;
   logic               dropped_ff, dropped_in;
   logic               rd_ok_ff, rd_ok_in;
   logic [IDLE_W-1:0]  timeout_ff, timeout_in;
   logic               xor_en_ff, xor_en_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_payload_ff, rsp_payload_in;

   logic               req_accept;
   logic               rsp_load;
   logic               csr_write;

   // memory ports
   logic               st_wr_en;
   logic               st_rd_en;
   logic [7:0]         st_rd_data;
   logic               meta_wr_en;
   logic               meta_rd_en;
   logic [LW-1:0]      close_len;
   logic [7:0]         close_xor;
   logic [LW-1:0]      meta_rd_len;
   logic [7:0]         meta_rd_xor;
   logic [SW-1:0]      tail_next;
   logic [SW-1:0]      head_next;

   assign head_next = (head_slot_ff == SLOT_LAST) ? '0 : head_slot_ff + 1'b1;
   assign tail_next = (tail_slot_ff == SLOT_LAST) ? '0 : tail_slot_ff + 1'b1;

   ufr_byte_store #(
      .FRAME_COUNT (FRAME_COUNT),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_byte_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_slot (head_slot_ff),
      .wr_pos  (head_len_ff[BW-1:0]),
      .wr_data (req_payload.rx_byte),
      .rd_en   (st_rd_en),
      .rd_slot (tail_slot_ff),
      .rd_pos  (BW'(req_payload.read_index)),
      .rd_data (st_rd_data)
   );

   ufr_meta_store #(
      .FRAME_COUNT (FRAME_COUNT),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_meta_store (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_slot (head_slot_ff),
      .wr_len  (close_len),
      .wr_xor  (close_xor),
      .rd_en   (meta_rd_en),
      .rd_slot (tail_next),
      .rd_len  (meta_rd_len),
      .rd_xor  (meta_rd_xor)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      req_accept = req_valid && (state_ff == ST_IDLE);
      rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
      csr_ready  = 1'b1;
      csr_write  = csr_valid;
   end

   // configuration registers
   always_comb begin
      timeout_in = timeout_ff;
      xor_en_in  = xor_en_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TIMEOUT:    timeout_in = csr_wdata[IDLE_W-1:0];
            CSR_XOR_ENABLE: xor_en_in  = csr_wdata[0];
            default:        timeout_in = timeout_ff;
         endcase
      end
   end

   // ring update
   always_comb begin : ring_update
      logic [IDLE_W-1:0] idle_tick;
      logic [UW-1:0]     used_dec;
      logic [LW-1:0]     tail_len_cur;
      logic              do_close;

      head_slot_in = head_slot_ff;
      tail_slot_in = tail_slot_ff;
      used_in      = used_ff;
      ovf_in       = ovf_ff;
      idle_in      = idle_ff;
      armed_in     = armed_ff;
      head_len_in  = head_len_ff;
      head_xor_in  = head_xor_ff;
      tail_len_in  = tail_len_ff;
      tail_xor_in  = tail_xor_ff;
      pend_in      = pend_ff;
      closed_in    = closed_ff;
      dropped_in   = dropped_ff;
      rd_ok_in     = rd_ok_ff;
      st_wr_en     = 1'b0;
      st_rd_en     = 1'b0;
      meta_wr_en   = 1'b0;
      meta_rd_en   = 1'b0;
      do_close     = 1'b0;
      close_len    = head_len_ff;
      close_xor    = head_xor_ff;
      idle_tick    = (idle_ff == '1) ? idle_ff : idle_ff + 1'b1;
      used_dec     = used_ff - 1'b1;
      tail_len_cur = (used_ff == '0) ? head_len_ff : tail_len_ff;

      // new tail frame arrives from the closed frame memory
      if ((state_ff == ST_FINISH) && pend_ff) begin
         tail_len_in = meta_rd_len;
         tail_xor_in = meta_rd_xor;
         pend_in     = 1'b0;
      end

      if (req_accept) begin
         closed_in  = 1'b0;
         dropped_in = 1'b0;
         rd_ok_in   = 1'b0;
         unique case (req_payload.mode)
            MODE_BYTE: begin
               if (ovf_ff || (head_len_ff >= LEN_MAX)) begin
                  dropped_in = 1'b1;
               end else begin
                  st_wr_en    = 1'b1;
                  close_len   = head_len_ff + 1'b1;
                  close_xor   = xor_en_ff ? (head_xor_ff ^ req_payload.rx_byte)
                                          : head_xor_ff;
                  head_len_in = close_len;
                  head_xor_in = close_xor;
                  idle_in     = '0;
                  armed_in    = 1'b1;
                  if (close_len >= LEN_MAX) begin
                     do_close = 1'b1;
                  end
               end
            end
            MODE_TICK: begin
               if (armed_ff) begin
                  idle_in = idle_tick;
                  if (idle_tick >= timeout_ff) begin
                     if (head_len_ff != '0) begin
                        do_close = 1'b1;
                     end else begin
                        armed_in = 1'b0;
                        idle_in  = '0;
                     end
                  end
               end
            end
            MODE_RELEASE: begin
               if (used_ff != '0) begin
                  tail_slot_in = tail_next;
                  used_in      = used_dec;
                  ovf_in       = 1'b0;
                  if (used_dec != '0) begin
                     meta_rd_en = 1'b1;
                     pend_in    = 1'b1;
                  end
               end
            end
            MODE_READ: begin
               st_rd_en = 1'b1;
               rd_ok_in = (CW'(req_payload.read_index) < CW'(tail_len_cur))
                          && (CW'(req_payload.read_index) < POS_LIMIT);
            end
            default: begin
               st_rd_en = 1'b0;
            end
         endcase

         if (do_close) begin
            closed_in    = 1'b1;
            meta_wr_en   = 1'b1;
            head_slot_in = head_next;
            used_in      = (used_ff < USED_MAX) ? used_ff + 1'b1 : used_ff;
            if (used_in >= USED_MAX) begin
               ovf_in = 1'b1;
            end
            armed_in    = 1'b0;
            idle_in     = '0;
            head_len_in = '0;
            head_xor_in = '0;
            if (used_ff == '0) begin
               tail_len_in = close_len;
               tail_xor_in = close_xor;
            end
         end
      end
   end

   // response register
   always_comb begin : rsp_build
      logic [LW-1:0] tail_len_out;
      logic [7:0]    tail_xor_out;

      if (used_ff == '0) begin
         tail_len_out = head_len_ff;
         tail_xor_out = head_xor_ff;
      end else if (pend_ff) begin
         tail_len_out = meta_rd_len;
         tail_xor_out = meta_rd_xor;
      end else begin
         tail_len_out = tail_len_ff;
         tail_xor_out = tail_xor_ff;
      end

      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.frames_used  = 3'(used_ff);
         rsp_payload_in.tail_length  = 7'(tail_len_out);
         rsp_payload_in.tail_xor     = tail_xor_out;
         rsp_payload_in.read_data    = rd_ok_ff ? st_rd_data : 8'd0;
         rsp_payload_in.frame_closed = closed_ff;
         rsp_payload_in.byte_dropped = dropped_ff;
         rsp_payload_in.overflow     = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_slot_ff <= '0;
         tail_slot_ff <= '0;
         used_ff      <= '0;
         ovf_ff       <= 1'b0;
         idle_ff      <= '0;
         armed_ff     <= 1'b0;
         head_len_ff  <= '0;
         head_xor_ff  <= '0;
         tail_len_ff  <= '0;
         tail_xor_ff  <= '0;
         pend_ff      <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
         xor_en_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_slot_ff <= head_slot_in;
         tail_slot_ff <= tail_slot_in;
         used_ff      <= used_in;
         ovf_ff       <= ovf_in;
         idle_ff      <= idle_in;
         armed_ff     <= armed_in;
         head_len_ff  <= head_len_in;
         head_xor_ff  <= head_xor_in;
         tail_len_ff  <= tail_len_in;
         tail_xor_ff  <= tail_xor_in;
         pend_ff      <= pend_in;
         timeout_ff   <= timeout_in;
         xor_en_ff    <= xor_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      closed_ff      <= closed_in;
      dropped_ff     <= dropped_in;
      rd_ok_ff       <= rd_ok_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: hw/rtl/ufr_checker.sv
// ----------------------------------------------------------------------------
// ufr_checker: port level checks of the receive frame ring
// Watches the top level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ufr_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input ufr_pkg::rsp_type      rsp_payload
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // one request in flight at a time
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // a new response only follows a request still in work
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a request");

   // a byte is either stored or dropped, never both closing and dropped
   a_close_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.frame_closed && rsp_payload.byte_dropped))
      else $error("frame closed by a dropped byte");

endmodule

bind uart_rx_frame_ring ufr_checker u_ufr_checker (.*);

// File: dv/uart_rx_frame_ring_tb.sv
// ----------------------------------------------------------------------------
// uart_rx_frame_ring_tb: self-checking bench for the receive frame ring
// Drives bytes, idle ticks, releases and tail reads through the request
// channel and checks every response against an in-bench model of the ring.
// Covers the idle timeout over its full range, frames closed by filling,
// ring overflow with dropped bytes, and long response back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module uart_rx_frame_ring_tb;
   import ufr_pkg::*;

   localparam int FRAME_COUNT = 4;
   localparam int FRAME_BYTES = 64;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   csr_index_type csr_index = CSR_TIMEOUT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // ring model state
   logic [7:0]        byte_mem [FRAME_COUNT*FRAME_BYTES];
   logic [6:0]        frame_len [FRAME_COUNT];
   logic [7:0]        frame_xor [FRAME_COUNT];
   logic [1:0]        head_slot, tail_slot;
   logic [2:0]        used_frames;
   logic              ring_full;
   logic [IDLE_W-1:0] idle_ticks;
   logic              timer_on;
   logic [IDLE_W-1:0] cfg_timeout = TIMEOUT_RESET;
   logic              xor_on = 1'b1;

   rsp_type predicted_rsps [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left = 0;
   int n_sent = 0, n_checked = 0, n_closed = 0, n_dropped = 0, n_reads = 0;
   int n_errors = 0;

   uart_rx_frame_ring #(
      .FRAME_COUNT (FRAME_COUNT),
      .FRAME_BYTES (FRAME_BYTES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void close_head_frame();
      head_slot = (head_slot == 2'(FRAME_COUNT - 1)) ? '0 : head_slot + 2'd1;
      if (used_frames < 3'(FRAME_COUNT)) used_frames = used_frames + 3'd1;
      if (used_frames >= 3'(FRAME_COUNT)) ring_full = 1'b1;
      timer_on = 1'b0;
      idle_ticks = '0;
   endfunction

   function automatic rsp_type ring_predict(input req_type item);
      rsp_type    r;
      logic [6:0] len;
      r = '0;
      case (item.mode)
         MODE_BYTE: begin
            len = frame_len[head_slot];
            if (ring_full || len >= 7'(FRAME_BYTES)) begin
               r.byte_dropped = 1'b1;
            end else begin
               byte_mem[{head_slot, len[5:0]}] = item.rx_byte;
               if (xor_on) frame_xor[head_slot] ^= item.rx_byte;
               frame_len[head_slot] = len + 7'd1;
               idle_ticks = '0;
               timer_on = 1'b1;
               if (int'(len) + 1 >= FRAME_BYTES) begin
                  close_head_frame();
                  r.frame_closed = 1'b1;
               end
            end
         end
         MODE_TICK: begin
            if (timer_on) begin
               if (idle_ticks != '1) idle_ticks = idle_ticks + 1'b1;
               if (idle_ticks >= cfg_timeout) begin
                  if (frame_len[head_slot] != '0) begin
                     close_head_frame();
                     r.frame_closed = 1'b1;
                  end else begin
                     timer_on = 1'b0;
                     idle_ticks = '0;
                  end
               end
            end
         end
         MODE_RELEASE: begin
            if (used_frames != '0) begin
               frame_len[tail_slot] = '0;
               frame_xor[tail_slot] = '0;
               tail_slot = (tail_slot == 2'(FRAME_COUNT - 1)) ? '0 : tail_slot + 2'd1;
               used_frames = used_frames - 3'd1;
               ring_full = 1'b0;
            end
         end
         default: begin
            if ({1'b0, item.read_index} < frame_len[tail_slot])
               r.read_data = byte_mem[{tail_slot, item.read_index}];
         end
      endcase
      r.frames_used = used_frames;
      r.tail_length = frame_len[tail_slot];
      r.tail_xor    = frame_xor[tail_slot];
      r.overflow    = ring_full;
      return r;
   endfunction

   function automatic string rsp_text(input rsp_type r);
      return $sformatf("used=%0d len=%0d xor=%02h data=%02h closed=%0b drop=%0b ovf=%0b",
                       r.frames_used, r.tail_length, r.tail_xor, r.read_data,
                       r.frame_closed, r.byte_dropped, r.overflow);
   endfunction

   task automatic flag_error(input string msg);
      n_errors++;
      if (n_errors <= 10) $display("%0t ERROR %s", $time, msg);
   endtask

   // one request transfer; the prediction is made when the transfer happens
   task automatic send_item(input mode_type m, input logic [7:0] b, input logic [5:0] idx);
      req_type item;
      item.mode = m;
      item.rx_byte = b;
      item.read_index = idx;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted_rsps.push_back(ring_predict(item));
      n_sent++;
      if (m == MODE_READ) n_reads++;
   endtask

   // register writes only once the ring has gone quiet
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      req_valid <= 1'b0;
      while (predicted_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_TIMEOUT) cfg_timeout = val;
      else xor_on = val[0];
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_rsps.size() == 0) begin
            flag_error({"response with nothing outstanding: ", rsp_text(rsp_payload)});
         end else begin
            want = predicted_rsps.pop_front();
            n_checked++;
            if (want.frame_closed) n_closed++;
            if (want.byte_dropped) n_dropped++;
            if (rsp_payload.frames_used !== want.frames_used ||
                rsp_payload.tail_length !== want.tail_length ||
                rsp_payload.tail_xor !== want.tail_xor ||
                rsp_payload.read_data !== want.read_data ||
                rsp_payload.frame_closed !== want.frame_closed ||
                rsp_payload.byte_dropped !== want.byte_dropped ||
                rsp_payload.overflow !== want.overflow)
               flag_error({"response ", $sformatf("%0d", n_checked), " exp ", rsp_text(want),
                           " got ", rsp_text(rsp_payload)});
         end
      end
   end

   // default timeout, basic operations and the quiet-ring corner cases
   task automatic test_directed();
      send_item(MODE_READ, 8'h00, 6'd0);
      send_item(MODE_READ, 8'hFF, 6'd63);
      send_item(MODE_TICK, 8'h00, 6'd0);
      send_item(MODE_RELEASE, 8'hFF, 6'd63);
      send_item(MODE_BYTE, 8'h00, 6'd63);
      send_item(MODE_BYTE, 8'hFF, 6'd0);
      send_item(MODE_BYTE, 8'hA5, 6'd21);
      send_item(MODE_READ, 8'h5A, 6'd1);
      send_item(MODE_READ, 8'h00, 6'd63);
      repeat (15) send_item(MODE_TICK, 8'($urandom), 6'($urandom));
      send_item(MODE_RELEASE, 8'($urandom), 6'($urandom));
   endtask

   // zero timeout closes on the first tick; xor accumulation off
   task automatic test_zero_timeout();
      write_csr(CSR_TIMEOUT, '0);
      write_csr(CSR_XOR_ENABLE, 16'd0);
      send_item(MODE_BYTE, 8'h3C, 6'($urandom));
      send_item(MODE_BYTE, 8'hC3, 6'($urandom));
      send_item(MODE_TICK, 8'($urandom), 6'($urandom));
      send_item(MODE_TICK, 8'($urandom), 6'($urandom));
      send_item(MODE_READ, 8'($urandom), 6'd0);
      send_item(MODE_READ, 8'($urandom), 6'd1);
      send_item(MODE_RELEASE, 8'($urandom), 6'($urandom));
      send_item(MODE_READ, 8'($urandom), 6'd0);
   endtask

   // four full frames fill the ring by length alone
   task automatic test_full_frames();
      write_csr(CSR_TIMEOUT, 16'd3);
      write_csr(CSR_XOR_ENABLE, 16'd1);
      repeat (FRAME_COUNT * FRAME_BYTES) send_item(MODE_BYTE, 8'($urandom), 6'($urandom));
      send_item(MODE_BYTE, 8'($urandom), 6'($urandom));
      send_item(MODE_TICK, 8'($urandom), 6'($urandom));
      send_item(MODE_READ, 8'($urandom), 6'd63);
      send_item(MODE_READ, 8'($urandom), 6'd0);
      repeat (FRAME_COUNT) begin
         send_item(MODE_RELEASE, 8'($urandom), 6'($urandom));
         send_item(MODE_READ, 8'($urandom), 6'($urandom));
      end
   endtask

   // ring overflow while the response side is held off for a long stretch
   task automatic test_overflow_backpressure();
      write_csr(CSR_TIMEOUT, 16'd1);
      hold_left <= 80;
      repeat (FRAME_COUNT) begin
         repeat ($urandom_range(1, 3)) send_item(MODE_BYTE, 8'($urandom), 6'($urandom));
         send_item(MODE_TICK, 8'($urandom), 6'($urandom));
      end
      repeat (3) send_item(MODE_BYTE, 8'($urandom), 6'($urandom));
      send_item(MODE_TICK, 8'($urandom), 6'($urandom));
      send_item(MODE_READ, 8'($urandom), 6'd0);
      send_item(MODE_READ, 8'($urandom), 6'd2);
      send_item(MODE_RELEASE, 8'($urandom), 6'($urandom));
      send_item(MODE_BYTE, 8'($urandom), 6'($urandom));
      send_item(MODE_TICK, 8'($urandom), 6'($urandom));
      repeat (FRAME_COUNT + 1) send_item(MODE_RELEASE, 8'($urandom), 6'($urandom));
   endtask

   // largest timeout holds the frame open; a lower one closes it on the next tick
   task automatic test_long_timeout();
      write_csr(CSR_TIMEOUT, 16'hFFFF);
      send_item(MODE_BYTE, 8'($urandom), 6'($urandom));
      repeat (40) send_item(MODE_TICK, 8'($urandom), 6'($urandom));
      send_item(MODE_READ, 8'($urandom), 6'd0);
      write_csr(CSR_TIMEOUT, 16'd41);
      send_item(MODE_TICK, 8'($urandom), 6'($urandom));
      send_item(MODE_RELEASE, 8'($urandom), 6'($urandom));
   endtask

   // mostly well-formed frames (bytes, then ticks to close), with noise
   task automatic test_random_traffic(input int count);
      int stop_at, pick;
      logic [5:0] idx;
      stop_at = n_sent + count;
      while (n_sent < stop_at) begin
         if ($urandom_range(7) == 0) begin
            pick = $urandom_range(19);
            write_csr(CSR_TIMEOUT, (pick == 0) ? 16'd0 :
                                   (pick == 1) ? 16'($urandom_range(20, 60)) :
                                                 16'($urandom_range(1, 6)));
            write_csr(CSR_XOR_ENABLE, 16'($urandom_range(1)));
         end
         if ($urandom_range(99) < 75) begin
            pick = ($urandom_range(9) == 0) ? $urandom_range(56, 64) : $urandom_range(1, 10);
            repeat (pick) send_item(MODE_BYTE, 8'($urandom), 6'($urandom));
            if ($urandom_range(3) != 0)
               while (timer_on) send_item(MODE_TICK, 8'($urandom), 6'($urandom));
         end else begin
            repeat ($urandom_range(1, 4))
               send_item(mode_type'($urandom_range(3)), 8'($urandom), 6'($urandom));
         end
         if ($urandom_range(99) < 60) begin
            repeat ($urandom_range(0, 3)) begin
               if (frame_len[tail_slot] != '0 && $urandom_range(3) != 0)
                  idx = 6'($urandom_range(int'(frame_len[tail_slot]) - 1));
               else
                  idx = 6'($urandom);
               send_item(MODE_READ, 8'($urandom), idx);
            end
            send_item(MODE_RELEASE, 8'($urandom), 6'($urandom));
         end
      end
   endtask

   initial begin
      foreach (frame_len[i]) begin
         frame_len[i] = '0;
         frame_xor[i] = '0;
      end
      head_slot = '0;
      tail_slot = '0;
      used_frames = '0;
      ring_full = 1'b0;
      idle_ticks = '0;
      timer_on = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 31;
      rsp_stall_pct = 52;
      test_directed();
      test_zero_timeout();
      test_random_traffic(120);

      send_idle_pct = 52;
      rsp_stall_pct = 31;
      test_full_frames();
      test_overflow_backpressure();
      test_random_traffic(120);

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_long_timeout();
      test_random_traffic(120);

      req_valid <= 1'b0;
      while (predicted_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d requests sent, %0d responses checked, %0d mismatches", n_sent, n_checked,
               n_errors);
      $display("%0d frames closed, %0d bytes dropped on overflow, %0d tail reads", n_closed,
               n_dropped, n_reads);
      if (n_errors == 0)
         $display("uart_rx_frame_ring test passed");
      else
         $display("uart_rx_frame_ring test failed");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("timeout with %0d responses outstanding", predicted_rsps.size());
      $display("uart_rx_frame_ring test failed");
      $finish;
   end

endmodule
